### sv/fifo_demand_page_loader_macros.svh
// Assertion macros shared by the page loader RTL.
// Define NO_ASSERTIONS to compile the checks out.
`ifndef FIFO_DEMAND_PAGE_LOADER_MACROS_SVH
`define FIFO_DEMAND_PAGE_LOADER_MACROS_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication.
`define FDPL_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define FDPL_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define FDPL_ASSERT_NOW(label, clk, rst_n, ante, cons, msg)
`define FDPL_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)

`endif

`endif

### sv/fdpl_pkg.sv
package fdpl_pkg;

    localparam int ADDR_W     = 32;
    localparam int PAGE_SHIFT = 12;
    localparam int FCNT_W     = 9;
    localparam int CFG_IDX_W  = 3;

    localparam logic [ADDR_W-1:0] PAGE_MASK = 32'hFFFF_F000;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_COUNT     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_POOL_BASE = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_APP0_IMAGE_BASE = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_APP1_IMAGE_BASE = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_VIRTUAL_BASE    = 3'd4;

    // Reset values of the configuration registers.
    localparam logic [FCNT_W-1:0] RST_FRAME_COUNT     = 9'd32;
    localparam logic [ADDR_W-1:0] RST_FRAME_POOL_BASE = 32'h44B0_0000;
    localparam logic [ADDR_W-1:0] RST_APP0_IMAGE_BASE = 32'h4410_0000;
    localparam logic [ADDR_W-1:0] RST_APP1_IMAGE_BASE = 32'h4450_0000;
    localparam logic [ADDR_W-1:0] RST_VIRTUAL_BASE    = 32'h3000_0000;

    // Command codes on the output channel.
    localparam logic CMD_EVICT   = 1'b0;
    localparam logic CMD_INSTALL = 1'b1;

    // One entry of the per-slot record store.
    typedef struct packed {
        logic [ADDR_W-1:0] page_tag;
        logic [ADDR_W-1:0] backing;
        logic              was_data;
    } t_slot_entry;

endpackage

### sv/fdpl_fault_if.sv
interface fdpl_fault_if;
    logic        valid;
    logic        ready;
    logic [31:0] fault_address;
    logic        application;
    logic        abort_kind;

    modport source (output valid, fault_address, application, abort_kind, input ready);
    modport sink   (input valid, fault_address, application, abort_kind, output ready);
endinterface

### sv/fdpl_cmd_if.sv
interface fdpl_cmd_if;
    logic        valid;
    logic        ready;
    logic        command;
    logic [31:0] page_address;
    logic [1:0]  space_tag;
    logic [31:0] frame_address;
    logic [31:0] backing_address;
    logic        write_back;
    logic        last;

    modport source (output valid, command, page_address, space_tag, frame_address,
                    backing_address, write_back, last, input ready);
    modport sink   (input valid, command, page_address, space_tag, frame_address,
                    backing_address, write_back, last, output ready);
endinterface

### sv/fifo_demand_page_loader.sv
// Demand-paging frame manager with round-robin victim choice. Each accepted
// fault beat picks the next frame slot; if that slot already holds a page the
// block first sends an evict beat (old page, its space tag, the frame, the
// stored backing-store address and a write-back flag set when the old page
// came in on a data abort), then an install beat for the faulting page with
// the frame address and the backing-store source address. The first command
// beat is offered in the cycle after the fault is accepted. A fault that
// evicts produces two command beats and one that finds its slot free produces
// one; the next fault is accepted in the same cycle that the install beat is
// taken. Both beats of a fault are sent from the single set of payload
// registers, so no fault is accepted while an evict beat is pending. Slot
// records live in a memory with one registered read port; the occupied flags
// are flip-flops cleared by reset, so no clearing pass is needed.
// Configuration must only be written while no fault is in flight.
`include "fifo_demand_page_loader_macros.svh"

module fifo_demand_page_loader
    import fdpl_pkg::*;
#(
    parameter int MAX_FRAMES = 256
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    fdpl_fault_if.sink           i_fault,
    fdpl_cmd_if.source           o_cmd,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [ADDR_W-1:0]    i_cfg_data
);

    // Slot index width, and a compare width that holds the frame count
    // register, MAX_FRAMES itself and a slot index plus one.
    localparam int SLOT_W = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
    localparam int CW_A   = (FCNT_W > SLOT_W + 1) ? FCNT_W : SLOT_W + 1;
    localparam int CNT_W  = $clog2(MAX_FRAMES + 1);
    localparam int CW     = (CW_A > CNT_W) ? CW_A : CNT_W;

    // Output sequencer states.
    localparam logic [1:0] ST_IDLE    = 2'd0;
    localparam logic [1:0] ST_EVICT   = 2'd1;
    localparam logic [1:0] ST_INSTALL = 2'd2;

    // Configuration registers.
    logic [FCNT_W-1:0] r_frame_count;
    logic [ADDR_W-1:0] r_frame_pool_base;
    logic [ADDR_W-1:0] r_app0_image_base;
    logic [ADDR_W-1:0] r_app1_image_base;
    logic [ADDR_W-1:0] r_virtual_base;

    // Control state.
    logic [1:0]        r_state, n_state;
    logic [SLOT_W-1:0] r_next_slot, n_next_slot;
    logic              r_slot_used [MAX_FRAMES];

    // Payload registers of the fault in flight.
    logic [ADDR_W-1:0] r_page;
    logic              r_app;
    logic [ADDR_W-1:0] r_src;
    logic [ADDR_W-1:0] r_dst;
    logic [SLOT_W-1:0] r_slot;

    logic              w_accept;
    logic              w_out_fire;
    logic [CW-1:0]     w_count;
    logic [CW-1:0]     w_fc;
    logic [SLOT_W-1:0] w_slot;
    logic [CW-1:0]     w_slot_inc;
    logic [ADDR_W-1:0] w_page;
    logic [ADDR_W-1:0] w_image;
    logic [ADDR_W-1:0] w_src;
    logic [ADDR_W-1:0] w_dst;
    logic              w_evict;
    t_slot_entry       w_wentry;
    t_slot_entry       w_rentry;

    // ------------------------------------------------------------------
    // Configuration port.
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_count     <= RST_FRAME_COUNT;
            r_frame_pool_base <= RST_FRAME_POOL_BASE;
            r_app0_image_base <= RST_APP0_IMAGE_BASE;
            r_app1_image_base <= RST_APP1_IMAGE_BASE;
            r_virtual_base    <= RST_VIRTUAL_BASE;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_FRAME_COUNT:     r_frame_count     <= i_cfg_data[FCNT_W-1:0];
                CFG_FRAME_POOL_BASE: r_frame_pool_base <= i_cfg_data;
                CFG_APP0_IMAGE_BASE: r_app0_image_base <= i_cfg_data;
                CFG_APP1_IMAGE_BASE: r_app1_image_base <= i_cfg_data;
                CFG_VIRTUAL_BASE:    r_virtual_base    <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Slot choice. A zero frame count acts as one and a count above the
    // pool size acts as the pool size. If the count was lowered to or below
    // the stored pointer, rotation restarts at slot zero.
    // ------------------------------------------------------------------
    assign w_fc = CW'(r_frame_count);

    always_comb begin
        priority if (w_fc == '0) begin
            w_count = CW'(1);
        end else if (w_fc > CW'(MAX_FRAMES)) begin
            w_count = CW'(MAX_FRAMES);
        end else begin
            w_count = w_fc;
        end
    end

    assign w_slot     = (CW'(r_next_slot) >= w_count) ? '0 : r_next_slot;
    assign w_slot_inc = CW'(w_slot) + CW'(1);
    assign n_next_slot = (w_slot_inc >= w_count) ? '0 : w_slot_inc[SLOT_W-1:0];

    // Addresses of the new page: 4 KiB aligned page, backing-store source
    // relative to the application's image, and the frame of the slot.
    assign w_page  = i_fault.fault_address & PAGE_MASK;
    assign w_image = i_fault.application ? r_app1_image_base : r_app0_image_base;
    assign w_src   = w_image + (w_page - r_virtual_base);
    assign w_dst   = r_frame_pool_base + (ADDR_W'(w_slot) << PAGE_SHIFT);

    // The space tag is the application number plus one.
    assign w_wentry.page_tag = {w_page[ADDR_W-1:PAGE_SHIFT],
                                (PAGE_SHIFT-2)'(0),
                                i_fault.application, ~i_fault.application};
    assign w_wentry.backing  = w_src;
    assign w_wentry.was_data = ~i_fault.abort_kind;

    // ------------------------------------------------------------------
    // Handshakes. A new fault may enter while the install beat of the
    // previous one is being taken.
    // ------------------------------------------------------------------
    assign w_out_fire    = o_cmd.valid & o_cmd.ready;
    assign i_fault.ready = (r_state == ST_IDLE) || ((r_state == ST_INSTALL) && o_cmd.ready);
    assign w_accept      = i_fault.valid & i_fault.ready;

    always_comb begin
        n_state = r_state;
        priority if (w_accept) begin
            n_state = r_slot_used[w_slot] ? ST_EVICT : ST_INSTALL;
        end else if (w_out_fire) begin
            n_state = (r_state == ST_EVICT) ? ST_INSTALL : ST_IDLE;
        end else begin
            n_state = r_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_next_slot <= '0;
            for (int i = 0; i < MAX_FRAMES; i++) begin
                r_slot_used[i] <= 1'b0;
            end
        end else begin
            r_state <= n_state;
            if (w_accept) begin
                r_next_slot         <= n_next_slot;
                r_slot_used[w_slot] <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_page <= w_page;
            r_app  <= i_fault.application;
            r_src  <= w_src;
            r_dst  <= w_dst;
            r_slot <= w_slot;
        end
    end

    // Old record of the slot comes out of the store as the new one goes in.
    fdpl_slot_store #(
        .DEPTH  (MAX_FRAMES),
        .SLOT_W (SLOT_W)
    ) u_store (
        .i_clk   (i_clk),
        .i_en    (w_accept),
        .i_addr  (w_slot),
        .i_wdata (w_wentry),
        .o_rdata (w_rentry)
    );

    // ------------------------------------------------------------------
    // Command beats.
    // ------------------------------------------------------------------
    assign w_evict = (r_state == ST_EVICT);

    assign o_cmd.valid           = (r_state != ST_IDLE);
    assign o_cmd.command         = w_evict ? CMD_EVICT : CMD_INSTALL;
    assign o_cmd.page_address    = w_evict ? (w_rentry.page_tag & PAGE_MASK) : r_page;
    assign o_cmd.space_tag       = w_evict ? w_rentry.page_tag[1:0] : {r_app, ~r_app};
    assign o_cmd.frame_address   = r_dst;
    assign o_cmd.backing_address = w_evict ? w_rentry.backing : r_src;
    assign o_cmd.write_back      = w_evict & w_rentry.was_data;
    assign o_cmd.last            = ~w_evict;

    // ------------------------------------------------------------------
    // Checks.
    // ------------------------------------------------------------------
    `FDPL_ASSERT_NEXT(a_accept_offers_beat, i_clk, i_rst_n, w_accept, o_cmd.valid, "no command beat after an accepted fault")
    `FDPL_ASSERT_NEXT(a_evict_then_install, i_clk, i_rst_n, w_out_fire && w_evict, o_cmd.valid && o_cmd.command == CMD_INSTALL, "evict beat not followed by install beat")
    `FDPL_ASSERT_NEXT(a_slot_marked_used, i_clk, i_rst_n, w_accept, r_slot_used[r_slot], "chosen slot not marked occupied")
    `FDPL_ASSERT_NOW(a_no_accept_on_evict, i_clk, i_rst_n, w_evict, !i_fault.ready, "fault taken while an evict beat is pending")

endmodule

### sv/fdpl_slot_store.sv
module fdpl_slot_store
    import fdpl_pkg::*;
#(
    parameter int DEPTH  = 256,
    parameter int SLOT_W = 8
) (
    input  logic              i_clk,
    input  logic              i_en,
    input  logic [SLOT_W-1:0] i_addr,
    input  t_slot_entry       i_wdata,
    output t_slot_entry       o_rdata
);

    t_slot_entry r_mem [DEPTH];
    t_slot_entry r_rdata;

    // Read-before-write: the old record of the slot comes out while the
    // new one goes in at the same edge.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rdata        <= r_mem[i_addr];
            r_mem[i_addr]  <= i_wdata;
        end
    end

    assign o_rdata = r_rdata;

endmodule
